[hw/rtl/tail_drop_packet_buffer_scheduler_assert.svh]
// assertion macros for the tail-drop packet buffer scheduler checker
// depends on nothing; included by the checker file
`ifndef TAIL_DROP_PACKET_BUFFER_SCHEDULER_ASSERT_SVH
`define TAIL_DROP_PACKET_BUFFER_SCHEDULER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TDPB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define TDPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/tdpb_pkg.sv]
// shared types and constants of the tail-drop packet buffer scheduler
// no dependencies
package tdpb_pkg;

	// width of the time fields on the ports
	localparam int FIELD_W = 32;

	// capacity register
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// commands from controller to datapath
	typedef struct packed {
		logic load;    // latch the incoming word
		logic pop;     // remove the oldest finish time
		logic decide;  // register drop flag and start time
		logic commit;  // push finish time, update ring, load result
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic pop_ok;  // ring not empty and oldest finish <= arrival
	} status_t;

endpackage

[hw/rtl/tdpb_if.sv]
// valid/ready channel interfaces: packet in, result out, capacity write
// depends on tdpb_pkg
interface tdpb_pkt_if;
	logic                          valid;
	logic                          ready;
	logic [tdpb_pkg::FIELD_W-1:0] arrival_time;
	logic [tdpb_pkg::FIELD_W-1:0] duration;
	logic                          last_in_batch;

	modport source (output valid, arrival_time, duration, last_in_batch, input ready);
	modport sink (input valid, arrival_time, duration, last_in_batch, output ready);
endinterface

interface tdpb_res_if;
	logic                          valid;
	logic                          ready;
	logic [tdpb_pkg::FIELD_W-1:0] start_time;
	logic                          dropped;
	logic                          last_result;

	modport source (output valid, start_time, dropped, last_result, input ready);
	modport sink (input valid, start_time, dropped, last_result, output ready);
endinterface

interface tdpb_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [tdpb_pkg::CAP_W-1:0] capacity;

	modport source (output valid, capacity, input ready);
	modport sink (input valid, capacity, output ready);
endinterface

[hw/rtl/tdpb_ctrl.sv]
// controller state machine: accept, pop loop, commit into the output register
// depends on tdpb_pkg
module tdpb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pkt_valid,
	output logic              pkt_ready,
	output logic              res_valid,
	input  logic              res_ready,
	input  tdpb_pkg::status_t status,
	output tdpb_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_CALC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// output slot is free when empty or being drained
	assign out_free  = !out_valid_q || res_ready;
	assign pkt_ready = (state_q == S_IDLE);
	assign res_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && pkt_valid;
		cmd.pop    = (state_q == S_POP) && status.pop_ok;
		cmd.decide = (state_q == S_POP) && !status.pop_ok;
		cmd.commit = (state_q == S_CALC) && out_free;
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pkt_valid) state_q <= S_POP;
				end
				S_POP: begin
					if (!status.pop_ok) state_q <= S_CALC;
				end
				S_CALC: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/tdpb_datapath.sv]
// datapath: finish-time ring memory, indexes, occupancy, capacity, result register
// depends on tdpb_pkg
module tdpb_datapath #(
	parameter int MAX_DEPTH = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tdpb_pkg::cmd_t                cmd,
	output tdpb_pkg::status_t             status,
	input  logic                          cfg_we,
	input  logic [tdpb_pkg::CAP_W-1:0]   cfg_capacity,
	input  logic [tdpb_pkg::FIELD_W-1:0] arrival_time,
	input  logic [tdpb_pkg::FIELD_W-1:0] duration,
	input  logic                          last_in_batch,
	output logic [tdpb_pkg::FIELD_W-1:0] start_time,
	output logic                          dropped,
	output logic                          last_result
);

	localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int OCC_W = $clog2(MAX_DEPTH + 1);
	localparam int CW    = (OCC_W > tdpb_pkg::CAP_W) ? OCC_W : tdpb_pkg::CAP_W;
	localparam logic [IDX_W-1:0] WRAP_IDX = IDX_W'(MAX_DEPTH - 1);

	logic [TIME_BITS-1:0] ring_mem [MAX_DEPTH];

	logic [IDX_W-1:0]           head_q, tail_q;
	logic [OCC_W-1:0]           occ_q;
	logic [tdpb_pkg::CAP_W-1:0] cap_q;
	logic [TIME_BITS-1:0]       arr_q, dur_q, start_q;
	logic                       last_q, drop_q;
	logic [TIME_BITS-1:0]       head_rd_q, newest_rd_q;
	logic [tdpb_pkg::FIELD_W-1:0] res_start_q;
	logic                       res_drop_q, res_last_q;

	logic [IDX_W-1:0]     head_inc, tail_inc, head_d, tail_d, newest_addr;
	logic [OCC_W-1:0]     occ_d;
	logic [CW-1:0]        eff_cap;
	logic                 full;
	logic [TIME_BITS-1:0] start_d, fin;
	logic [TIME_BITS:0]   sum;
	logic                 push;

	// index wrap
	assign head_inc    = (head_q == WRAP_IDX) ? '0 : head_q + 1'b1;
	assign tail_inc    = (tail_q == WRAP_IDX) ? '0 : tail_q + 1'b1;
	assign newest_addr = (tail_d == '0) ? WRAP_IDX : tail_d - 1'b1;

	assign push = cmd.commit && !drop_q;

	// next ring pointers and occupancy
	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		occ_d  = occ_q;
		if (cmd.commit && last_q) begin
			head_d = '0;
			tail_d = '0;
			occ_d  = '0;
		end else if (push) begin
			tail_d = tail_inc;
			occ_d  = occ_q + 1'b1;
		end else if (cmd.pop) begin
			head_d = head_inc;
			occ_d  = occ_q - 1'b1;
		end
	end

	// oldest entry expires at or before arrival
	assign status.pop_ok = (occ_q != '0) && (head_rd_q <= arr_q);

	// effective capacity, clamped to 1..MAX_DEPTH
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (CW'(cap_q) > CW'(MAX_DEPTH)) begin
			eff_cap = CW'(MAX_DEPTH);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	// drop decision and start time
	assign full = CW'(occ_q) >= eff_cap;
	always_comb begin
		if (full) begin
			start_d = '0;
		end else if ((occ_q != '0) && (newest_rd_q > arr_q)) begin
			start_d = newest_rd_q;
		end else begin
			start_d = arr_q;
		end
	end

	// saturating finish time
	assign sum = {1'b0, start_q} + {1'b0, dur_q};
	assign fin = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
			cap_q  <= tdpb_pkg::CAP_RESET;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			occ_q  <= occ_d;
			if (cfg_we) cap_q <= cfg_capacity;
		end
	end

	// working word and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			arr_q  <= TIME_BITS'(arrival_time);
			dur_q  <= TIME_BITS'(duration);
			last_q <= last_in_batch;
		end
		if (cmd.decide) begin
			drop_q  <= full;
			start_q <= start_d;
		end
		if (cmd.commit) begin
			res_start_q <= tdpb_pkg::FIELD_W'(start_q);
			res_drop_q  <= drop_q;
			res_last_q  <= last_q;
		end
	end

	// ring memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (push) ring_mem[tail_q] <= fin;
		head_rd_q   <= ring_mem[head_d];
		newest_rd_q <= ring_mem[newest_addr];
	end

	assign start_time  = res_start_q;
	assign dropped     = res_drop_q;
	assign last_result = res_last_q;

endmodule

[hw/rtl/tail_drop_packet_buffer_scheduler.sv]
// sequence: accept, one pop step per expired entry, decide, then commit into the result register
// a new packet is accepted only after the previous one commits; a stalled result holds
// the packet at its commit step
// reset: arst_n clears the ring to empty and capacity to 16; no clearing pass
// top level of the tail-drop packet buffer scheduler
// depends on tdpb_pkg, tdpb_if, tdpb_ctrl, tdpb_datapath
module tail_drop_packet_buffer_scheduler #(
	parameter int MAX_DEPTH = 16,
	parameter int TIME_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	tdpb_pkt_if.sink   pkt,
	tdpb_res_if.source res,
	tdpb_cfg_if.sink   cfg
);

	tdpb_pkg::cmd_t    cmd;
	tdpb_pkg::status_t status;

	// capacity writes are always taken
	assign cfg.ready = 1'b1;

	// sequencer
	tdpb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt.valid),
		.pkt_ready (pkt.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// ring and arithmetic
	tdpb_datapath #(
		.MAX_DEPTH (MAX_DEPTH),
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg.valid),
		.cfg_capacity  (cfg.capacity),
		.arrival_time  (pkt.arrival_time),
		.duration      (pkt.duration),
		.last_in_batch (pkt.last_in_batch),
		.start_time    (res.start_time),
		.dropped       (res.dropped),
		.last_result   (res.last_result)
	);

endmodule

[hw/rtl/tdpb_checker.sv]
// port-level checker for the tail-drop packet buffer scheduler, with its bind
// depends on tail_drop_packet_buffer_scheduler_assert.svh and tdpb_pkg
`include "tail_drop_packet_buffer_scheduler_assert.svh"

module tdpb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pkt_valid,
	input logic                          pkt_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [tdpb_pkg::FIELD_W-1:0] res_start_time,
	input logic                          res_dropped,
	input logic                          res_last_result
);

	// a stalled result word holds
	`TDPB_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_start_time) && $stable(res_dropped) && $stable(res_last_result), "result word changed while stalled")

	// a dropped packet reports zero start time
	`TDPB_ASSERT_NOW(a_drop_zero, clk, arst_n, res_valid && res_dropped, res_start_time == '0, "dropped packet with nonzero start time")

	// one packet in work at a time
	`TDPB_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, pkt_valid && pkt_ready, !pkt_ready, "packet accepted while previous one in work")

endmodule

bind tail_drop_packet_buffer_scheduler tdpb_checker u_tdpb_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.pkt_valid       (pkt.valid),
	.pkt_ready       (pkt.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_start_time  (res.start_time),
	.res_dropped     (res.dropped),
	.res_last_result (res.last_result)
);
